// ===== sv/jet_pkg.sv =====
// Shared types, register codes and fixed-point helpers for the Julia escape-time unit.
package jet_pkg;

   // Fixed-point format: signed Q4.28
   localparam int Q_FRAC = 28;
   localparam int Q_W    = 32;
   // Width that holds every pre-saturation sum in this design
   localparam int SUM_W  = 42;

   // 4.0 in unsigned Q8.56
   localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_C_REAL         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_C_IMAG         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_REAL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_IMAG    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_STEP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = 3'd5;

   // Register reset values
   localparam logic signed [31:0] C_REAL_RST      = -32'sd214748365;
   localparam logic signed [31:0] C_IMAG_RST      = -32'sd23890756;
   localparam logic signed [31:0] ORIGIN_REAL_RST = -32'sd469762048;
   localparam logic signed [31:0] ORIGIN_IMAG_RST = -32'sd469762048;
   localparam logic [30:0]        PIXEL_STEP_RST  = 31'd917504;
   localparam logic [15:0]        MAX_ITER_RST    = 16'd1000;

   // Most negative and most positive Q4.28 values
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [15:0] escape_count;
      logic        inside_res;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] c_real;
      logic signed [31:0] c_imag;
      logic signed [31:0] origin_real;
      logic signed [31:0] origin_imag;
      logic [30:0]        pixel_step;
      logic [15:0]        max_iterations;
   } cfg_type;

   // Operand pairs for the three multipliers of the shared unit
   typedef struct packed {
      logic signed [31:0] a0;
      logic signed [31:0] b0;
      logic signed [31:0] a1;
      logic signed [31:0] b1;
      logic signed [31:0] a2;
      logic signed [31:0] b2;
   } mul_req_type;

   typedef struct packed {
      logic signed [63:0] p0;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
   } mul_rsp_type;

   // Clamp a wide two's complement sum to the Q4.28 range
   function automatic logic signed [31:0] sat_q(input logic [SUM_W-1:0] v);
      logic [SUM_W-Q_W:0] top;
      top = v[SUM_W-1:Q_W-1];
      if (top == '0 || top == '1) begin
         return v[Q_W-1:0];
      end else if (v[SUM_W-1]) begin
         return Q_MIN;
      end else begin
         return Q_MAX;
      end
   endfunction

endpackage

// ===== sv/jet_csr.sv =====
// Configuration register bank of the Julia escape-time unit.
module jet_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [jet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data,
   output jet_pkg::cfg_type               cfg
);

   jet_pkg::cfg_type cfg_ff;
   jet_pkg::cfg_type cfg_in;

   // Always take writes; the bank has no busy time
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write; drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            jet_pkg::CSR_C_REAL:         cfg_in.c_real         = csr_data;
            jet_pkg::CSR_C_IMAG:         cfg_in.c_imag         = csr_data;
            jet_pkg::CSR_ORIGIN_REAL:    cfg_in.origin_real    = csr_data;
            jet_pkg::CSR_ORIGIN_IMAG:    cfg_in.origin_imag    = csr_data;
            jet_pkg::CSR_PIXEL_STEP:     cfg_in.pixel_step     = csr_data[30:0];
            jet_pkg::CSR_MAX_ITERATIONS: cfg_in.max_iterations = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_real         <= jet_pkg::C_REAL_RST;
         cfg_ff.c_imag         <= jet_pkg::C_IMAG_RST;
         cfg_ff.origin_real    <= jet_pkg::ORIGIN_REAL_RST;
         cfg_ff.origin_imag    <= jet_pkg::ORIGIN_IMAG_RST;
         cfg_ff.pixel_step     <= jet_pkg::PIXEL_STEP_RST;
         cfg_ff.max_iterations <= jet_pkg::MAX_ITER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/jet_cmul.sv =====
// Shared multiply unit: three registered 32 x 32 signed products.
module jet_cmul (
   input  logic                  clock,
   input  jet_pkg::mul_req_type  mul_req,
   output jet_pkg::mul_rsp_type  mul_rsp
);

   jet_pkg::mul_rsp_type prod_ff;
   jet_pkg::mul_rsp_type prod_in;

   // Full-width signed products
   always_comb begin
      prod_in.p0 = mul_req.a0 * mul_req.b0;
      prod_in.p1 = mul_req.a1 * mul_req.b1;
      prod_in.p2 = mul_req.a2 * mul_req.b2;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_rsp = prod_ff;

endmodule

// ===== sv/jet_seq.sv =====
// Sequencer and iterate datapath: start point, z update, escape test, result register.
module jet_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  jet_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  jet_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output jet_pkg::rsp_type      rsp_data,
   output jet_pkg::mul_req_type  mul_req,
   input  jet_pkg::mul_rsp_type  mul_rsp
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCALE,
      S_START,
      S_SQUARE,
      S_UPDATE
   } state_type;

   state_type           state_ff, state_in;
   logic [9:0]          px_ff, px_in;
   logic [9:0]          py_ff, py_in;
   logic signed [31:0]  zr_ff, zr_in;
   logic signed [31:0]  zi_ff, zi_in;
   logic [15:0]         count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   jet_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic [jet_pkg::SUM_W-1:0] start_re;
   logic [jet_pkg::SUM_W-1:0] start_im;
   logic signed [63:0]        re_full;
   logic signed [63:0]        re_shift;
   logic signed [63:0]        im_shift;
   logic [jet_pkg::SUM_W-1:0] next_re;
   logic [jet_pkg::SUM_W-1:0] next_im;
   logic [63:0]               mag;
   logic                      escape;
   logic                      limit_hit;
   logic                      out_free;

   // Feed the shared unit: pixel scaling during S_SCALE, z squares otherwise; the third product is always zr*zi
   always_comb begin
      if (state_ff == S_SCALE) begin
         mul_req.a0 = {1'b0, cfg.pixel_step};
         mul_req.b0 = {22'd0, px_ff};
         mul_req.a1 = {1'b0, cfg.pixel_step};
         mul_req.b1 = {22'd0, py_ff};
      end else begin
         mul_req.a0 = zr_ff;
         mul_req.b0 = zr_ff;
         mul_req.a1 = zi_ff;
         mul_req.b1 = zi_ff;
      end
      mul_req.a2 = zr_ff;
      mul_req.b2 = zi_ff;
   end

   // Start point: origin plus index times step
   assign start_re = {{(jet_pkg::SUM_W-32){cfg.origin_real[31]}}, cfg.origin_real}
                     + mul_rsp.p0[jet_pkg::SUM_W-1:0];
   assign start_im = {{(jet_pkg::SUM_W-32){cfg.origin_imag[31]}}, cfg.origin_imag}
                     + mul_rsp.p1[jet_pkg::SUM_W-1:0];

   // Next z: floored products plus c
   assign re_full  = mul_rsp.p0 - mul_rsp.p1;
   assign re_shift = re_full >>> jet_pkg::Q_FRAC;
   assign im_shift = mul_rsp.p2 >>> (jet_pkg::Q_FRAC - 1);
   assign next_re  = re_shift[jet_pkg::SUM_W-1:0]
                     + {{(jet_pkg::SUM_W-32){cfg.c_real[31]}}, cfg.c_real};
   assign next_im  = im_shift[jet_pkg::SUM_W-1:0]
                     + {{(jet_pkg::SUM_W-32){cfg.c_imag[31]}}, cfg.c_imag};

   // Escape test on the squares of the current z, exact in Q8.56
   assign mag       = mul_rsp.p0 + mul_rsp.p1;
   assign escape    = mag > jet_pkg::ESCAPE_LIMIT;
   assign limit_hit = count_ff == cfg.max_iterations;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Advance the sequencer
   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               px_in    = req_data.pixel_x;
               py_in    = req_data.pixel_y;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            state_in = S_START;
         end
         S_START: begin
            zr_in    = jet_pkg::sat_q(start_re);
            zi_in    = jet_pkg::sat_q(start_im);
            count_in = '0;
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (limit_hit || escape) begin
               // Hold here until the result register is free
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  if (limit_hit) begin
                     rsp_data_in.escape_count = '0;
                     rsp_data_in.inside_res   = 1'b1;
                  end else begin
                     rsp_data_in.escape_count = count_ff;
                     rsp_data_in.inside_res   = 1'b0;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               zr_in    = jet_pkg::sat_q(next_re);
               zi_in    = jet_pkg::sat_q(next_im);
               count_in = count_ff + 16'd1;
               state_in = S_SQUARE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted item starts the scaling step
   a_accept_scale: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_SCALE)
      else $error("accepted item did not start scaling");

   // The count never passes the limit while iterating
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQUARE || state_ff == S_UPDATE) |-> count_ff <= cfg.max_iterations)
      else $error("iteration count passed the limit");

   // A z part pinned at the negative limit must escape on its test
   a_sat_escapes: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPDATE && (zr_ff == jet_pkg::Q_MIN || zi_ff == jet_pkg::Q_MIN)
      |-> escape)
      else $error("saturated z failed the escape test");

   // An inside result always carries a zero count
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.inside_res |-> rsp_data_ff.escape_count == '0)
      else $error("inside result with non-zero count");

endmodule

// ===== sv/julia_escape_time_unit.sv =====
// Top level of the Julia escape-time unit: register bank, sequencer and shared multiplier.
// Each item is one pixel (pixel_x, pixel_y). The unit maps it to the start point
// origin + index * pixel_step, iterates z = z*z + c in signed Q4.28 and returns the
// number of iterations before |z|^2 exceeds 4, or zero with inside_res set when
// max_iterations is reached. One item is in work at a time: the unit accepts no new item
// until the current one has finished and its result has gone into the output register.
// The loop runs through the shared multiply unit: in S_SQUARE it forms the two squares
// and the cross product of z, and in S_UPDATE z is tested and updated. A finished
// result waits in its output register while the next item is taken; if the previous
// result is still held there when an item finishes, the unit stays busy until that
// result is taken. Configuration writes are taken every cycle and must be made while
// the unit is idle; indexes past the last register are ignored.
module julia_escape_time_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  jet_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output jet_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [jet_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data
);

   jet_pkg::cfg_type      cfg;
   jet_pkg::mul_req_type  mul_req;
   jet_pkg::mul_rsp_type  mul_rsp;

   jet_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   jet_cmul u_cmul (
      .clock   (clock),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   jet_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mul_req   (mul_req),
      .mul_rsp   (mul_rsp)
   );

endmodule
